>>> hw/rtl/bsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bsm_pkg;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_TICK  = 2'd1,
    OP_PRG   = 2'd2,
    OP_CHR   = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
    logic        rendering_on;
  } in_word_t;

  typedef struct packed {
    logic [20:0] rom_address;
    logic        irq_line;
    logic [1:0]  mirroring;
    logic        ram_enable;
    logic        ram_protect;
  } out_word_t;

  typedef logic [7:0][7:0] bank_arr_t;

  localparam bank_arr_t BANK_INIT =
    {8'd1, 8'd0, 8'd7, 8'd6, 8'd5, 8'd4, 8'd2, 8'd0};

  // register decode uses address bits 15:13 and 0
  localparam logic [15:0] REG_MASK       = 16'hE001;
  localparam logic [15:0] REG_MODE       = 16'h8000;
  localparam logic [15:0] REG_BANK       = 16'h8001;
  localparam logic [15:0] REG_MIRROR     = 16'hA000;
  localparam logic [15:0] REG_RAM_CTRL   = 16'hA001;
  localparam logic [15:0] REG_IRQ_RELOAD = 16'hC000;
  localparam logic [15:0] REG_IRQ_CLEAR  = 16'hC001;
  localparam logic [15:0] REG_IRQ_OFF    = 16'hE000;
  localparam logic [15:0] REG_IRQ_ON     = 16'hE001;

  localparam logic CFG_PRG_LAST    = 1'b0;
  localparam logic CFG_FOUR_SCREEN = 1'b1;

  localparam logic [1:0] MIRROR_FOUR = 2'd2;

  localparam int MODE_PRG_SWAP = 6;
  localparam int MODE_CHR_INV  = 7;

endpackage

`default_nettype wire

>>> hw/rtl/bsm_xlate.sv
`timescale 1ns / 1ps
`default_nettype none

module bsm_xlate (
  input  wire logic [1:0]       opcode,
  input  wire logic [15:0]      bus_address,
  input  wire logic [7:0]       mode_byte,
  input  wire bsm_pkg::bank_arr_t bank_regs,
  input  wire logic [7:0]       prg_last_bank,
  output logic [20:0]           rom_address
);
  import bsm_pkg::*;

  logic [7:0]  prg_bank;
  logic [7:0]  second_last;
  logic [20:0] prg_addr;
  logic [12:0] chr_a;
  logic [2:0]  chr_sel;
  logic [7:0]  chr_bank;
  logic [20:0] chr_addr;

  assign second_last = prg_last_bank - 8'd1;

  always_comb begin
    case (bus_address[14:13])
      2'd0:    prg_bank = mode_byte[MODE_PRG_SWAP] ? second_last : bank_regs[6];
      2'd1:    prg_bank = bank_regs[7];
      2'd2:    prg_bank = mode_byte[MODE_PRG_SWAP] ? bank_regs[6] : second_last;
      default: prg_bank = prg_last_bank;
    endcase
    prg_addr = bus_address[15] ? {prg_bank, bus_address[12:0]} : '0;
  end

  // bit 7 of mode swaps the two pattern halves
  assign chr_a = bus_address[12:0] ^ {mode_byte[MODE_CHR_INV], 12'd0};

  always_comb begin
    if (!chr_a[12]) begin
      chr_sel  = {2'd0, chr_a[11]};
      chr_bank = bank_regs[chr_sel];
      chr_addr = {3'd0, chr_bank[7:1], chr_a[10:0]};
    end else begin
      chr_sel  = {1'b0, chr_a[11:10]} + 3'd2;
      chr_bank = bank_regs[chr_sel];
      chr_addr = {3'd0, chr_bank, chr_a[9:0]};
    end
    if (bus_address[15:13] != 3'd0) begin
      chr_addr = '0;
    end
  end

  always_comb begin
    case (opcode)
      OP_PRG:  rom_address = prg_addr;
      OP_CHR:  rom_address = chr_addr;
      default: rom_address = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/bank_switch_mapper_scanline_irq.sv
`timescale 1ns / 1ps
`default_nettype none
// channel | handshake             | payload
// in      | in_valid / in_ready   | in_word  (opcode, bus_address, write_data, rendering_on)
// out     | out_valid / out_ready | out_word (rom_address, irq_line, mirroring, ram_*)
// cfg     | cfg_we                | cfg_index, cfg_data
//
// One word per cycle while in_ready is high; each result appears in the cycle after its word is taken.
// Mapper state updates at the accepting edge; the output register holds the result.
// in_ready drops only while a result sits unread and out_ready is low.
// Synchronous active-low reset restores the bank, mode and counter registers.

module bank_switch_mapper_scanline_irq (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire bsm_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output bsm_pkg::out_word_t      out_word,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [7:0]         cfg_data
);
  import bsm_pkg::*;

  logic [7:0] prg_last_r;
  logic       four_screen_r;
  bank_arr_t  bank_regs_r, bank_regs_nxt;
  logic [7:0] mode_byte_r, mode_byte_nxt;
  logic       mirror_r, mirror_nxt;
  logic [1:0] ram_ctrl_r, ram_ctrl_nxt;
  logic [7:0] irq_reload_r, irq_reload_nxt;
  logic [7:0] irq_count_r, irq_count_nxt;
  logic       irq_on_r, irq_on_nxt;
  logic       irq_pending_r, irq_pending_nxt;
  logic       out_valid_r;
  out_word_t  out_word_r, out_word_nxt;
  logic       in_fire;
  logic [15:0] reg_sel;
  logic [7:0]  count_step;
  logic [20:0] rom_addr;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign reg_sel  = in_word.bus_address & REG_MASK;
  assign count_step = (irq_count_r == 8'd0) ? irq_reload_r : irq_count_r - 8'd1;

  bsm_xlate u_xlate (
    .opcode        (in_word.opcode),
    .bus_address   (in_word.bus_address),
    .mode_byte     (mode_byte_r),
    .bank_regs     (bank_regs_r),
    .prg_last_bank (prg_last_r),
    .rom_address   (rom_addr)
  );

  always_comb begin
    bank_regs_nxt   = bank_regs_r;
    mode_byte_nxt   = mode_byte_r;
    mirror_nxt      = mirror_r;
    ram_ctrl_nxt    = ram_ctrl_r;
    irq_reload_nxt  = irq_reload_r;
    irq_count_nxt   = irq_count_r;
    irq_on_nxt      = irq_on_r;
    irq_pending_nxt = irq_pending_r;
    if (in_word.opcode == OP_WRITE) begin
      case (reg_sel)
        REG_MODE:       mode_byte_nxt = in_word.write_data;
        REG_BANK:       bank_regs_nxt[mode_byte_r[2:0]] = in_word.write_data;
        REG_MIRROR:     mirror_nxt = in_word.write_data[0];
        REG_RAM_CTRL:   ram_ctrl_nxt = in_word.write_data[7:6];
        REG_IRQ_RELOAD: irq_reload_nxt = in_word.write_data;
        REG_IRQ_CLEAR:  irq_count_nxt = 8'd0;
        REG_IRQ_OFF: begin
          irq_on_nxt      = 1'b0;
          irq_pending_nxt = 1'b0;
        end
        REG_IRQ_ON:     irq_on_nxt = 1'b1;
        default:        ;
      endcase
    end else if (in_word.opcode == OP_TICK && in_word.rendering_on) begin
      irq_count_nxt = count_step;
      if (count_step == 8'd0) begin
        irq_pending_nxt = irq_on_r;
      end
    end
    out_word_nxt.rom_address = rom_addr;
    out_word_nxt.irq_line    = irq_pending_nxt;
    out_word_nxt.mirroring   = four_screen_r ? MIRROR_FOUR : {1'b0, mirror_nxt};
    out_word_nxt.ram_enable  = ram_ctrl_nxt[1];
    out_word_nxt.ram_protect = ram_ctrl_nxt[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_last_r    <= 8'd31;
      four_screen_r <= 1'b0;
      bank_regs_r   <= BANK_INIT;
      mode_byte_r   <= 8'd0;
      mirror_r      <= 1'b1;
      ram_ctrl_r    <= 2'd0;
      irq_reload_r  <= 8'd0;
      irq_count_r   <= 8'd0;
      irq_on_r      <= 1'b0;
      irq_pending_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_PRG_LAST) begin
          prg_last_r <= cfg_data;
        end else begin
          four_screen_r <= cfg_data[0];
        end
      end
      if (in_fire) begin
        bank_regs_r   <= bank_regs_nxt;
        mode_byte_r   <= mode_byte_nxt;
        mirror_r      <= mirror_nxt;
        ram_ctrl_r    <= ram_ctrl_nxt;
        irq_reload_r  <= irq_reload_nxt;
        irq_count_r   <= irq_count_nxt;
        irq_on_r      <= irq_on_nxt;
        irq_pending_r <= irq_pending_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload register: load on every accepted word
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef SYNTH
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("in_ready low with empty output register");

  a_irq_off_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_word.opcode == OP_WRITE && reg_sel == REG_IRQ_OFF
      |=> !irq_pending_r && !out_word.irq_line)
    else $error("interrupt disable did not clear pending flag");

  a_no_addr_for_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_word.opcode == OP_WRITE || in_word.opcode == OP_TICK)
      |=> out_word.rom_address == 21'd0)
    else $error("nonzero ROM address for write or tick");

  a_idle_tick_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_word.opcode == OP_TICK && !in_word.rendering_on
      |=> $stable(irq_count_r) && $stable(irq_pending_r))
    else $error("tick with rendering off moved the counter");
`endif

endmodule

`default_nettype wire

>>> verif/mapper_checker.sv
`timescale 1ns / 1ps

module mapper_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  bsm_pkg::in_word_t  in_word,
  input  logic               out_valid,
  input  logic               out_ready,
  input  bsm_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data,
  output int                 fail_count,
  output int                 results_due
);
  import bsm_pkg::*;

  localparam logic [15:0] CHR_SPACE_END = 16'h2000;

  // mapper state as seen by the checker
  logic [7:0] bank_reg [8];
  logic [7:0] top_bank;
  logic       four_scr;
  logic [7:0] mode_reg;
  logic       mirror_reg;
  logic [1:0] wram_ctrl;
  logic [7:0] reload_val;
  logic [7:0] irq_counter;
  logic       irq_armed;
  logic       pend_flag;

  out_word_t  expected_q [$];

  function automatic logic [20:0] prg_rom_addr(input logic [15:0] a);
    logic [7:0] bank;
    logic [7:0] next_to_last;
    logic       swap;
    next_to_last = top_bank - 8'd1;
    swap = mode_reg[MODE_PRG_SWAP];
    if (!a[15]) return '0;
    case (a[14:13])
      2'd0:    bank = swap ? next_to_last : bank_reg[6];
      2'd1:    bank = bank_reg[7];
      2'd2:    bank = swap ? bank_reg[6] : next_to_last;
      default: bank = top_bank;
    endcase
    return {bank, a[12:0]};
  endfunction

  function automatic logic [20:0] chr_rom_addr(input logic [15:0] a);
    logic [12:0] p;
    logic [7:0]  bank;
    if (a >= CHR_SPACE_END) return '0;
    p = a[12:0] ^ {mode_reg[MODE_CHR_INV], 12'd0};
    // low half: two 2K banks, bank bit 0 ignored
    if (!p[12]) return {3'd0, bank_reg[p[11]][7:1], p[10:0]};
    bank = bank_reg[3'd2 + {1'b0, p[11:10]}];
    return {3'd0, bank, p[9:0]};
  endfunction

  task automatic step_mapper(input in_word_t w, output out_word_t r);
    logic [20:0] rom;
    rom = '0;
    case (op_t'(w.opcode))
      OP_WRITE: begin
        case (w.bus_address & REG_MASK)
          REG_MODE:       mode_reg = w.write_data;
          REG_BANK:       bank_reg[mode_reg[2:0]] = w.write_data;
          REG_MIRROR:     mirror_reg = w.write_data[0];
          REG_RAM_CTRL:   wram_ctrl = w.write_data[7:6];
          REG_IRQ_RELOAD: reload_val = w.write_data;
          REG_IRQ_CLEAR:  irq_counter = '0;
          REG_IRQ_OFF: begin
            irq_armed = 1'b0;
            pend_flag = 1'b0;
          end
          REG_IRQ_ON:     irq_armed = 1'b1;
          default: ;
        endcase
      end
      OP_TICK: begin
        if (w.rendering_on) begin
          irq_counter = (irq_counter == 8'd0) ? reload_val : irq_counter - 8'd1;
          if (irq_counter == 8'd0) pend_flag = irq_armed;
        end
      end
      OP_PRG:  rom = prg_rom_addr(w.bus_address);
      default: rom = chr_rom_addr(w.bus_address);
    endcase
    r.rom_address = rom;
    r.irq_line    = pend_flag;
    r.mirroring   = four_scr ? MIRROR_FOUR : {1'b0, mirror_reg};
    r.ram_enable  = wram_ctrl[1];
    r.ram_protect = wram_ctrl[0];
  endtask

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("t=%0t %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    out_word_t predicted;
    out_word_t want;
    if (!rst_n) begin
      bank_reg    = '{8'd0, 8'd2, 8'd4, 8'd5, 8'd6, 8'd7, 8'd0, 8'd1};
      top_bank    = 8'd31;
      four_scr    = 1'b0;
      mode_reg    = '0;
      mirror_reg  = 1'b1;
      wram_ctrl   = '0;
      reload_val  = '0;
      irq_counter = '0;
      irq_armed   = 1'b0;
      pend_flag   = 1'b0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_PRG_LAST) top_bank = cfg_data;
        else four_scr = cfg_data[0];
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("t=%0t unexpected result word: expected none, actual 0x%0h",
                   $time, out_word);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("rom_address", want.rom_address, out_word.rom_address);
          check_field("irq_line", want.irq_line, out_word.irq_line);
          check_field("mirroring", want.mirroring, out_word.mirroring);
          check_field("ram_enable", want.ram_enable, out_word.ram_enable);
          check_field("ram_protect", want.ram_protect, out_word.ram_protect);
        end
      end
      if (in_valid && in_ready) begin
        step_mapper(in_word, predicted);
        expected_q.push_back(predicted);
      end
    end
    results_due = expected_q.size();
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import bsm_pkg::*;

  localparam int PHASES       = 5;
  localparam int RANDOM_WORDS = 1800;
  localparam int STALL_LIMIT  = 2000;
  localparam int LONG_HOLD    = 160;
  localparam int HOLD_AT      = 1500;

  typedef enum int {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_word_t   in_word;
  logic       out_valid;
  logic       out_ready;
  out_word_t  out_word;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_data;

  int fail_count;
  int results_due;
  int quiet_cycles = 0;
  int burst_left   = 0;

  bank_switch_mapper_scanline_irq dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mapper_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_word    (out_word),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic in_word_t mk(input op_t op, input logic [15:0] a,
                                  input logic [7:0] d, input logic r);
    in_word_t w;
    w.opcode       = op;
    w.bus_address  = a;
    w.write_data   = d;
    w.rendering_on = r;
    return w;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int       pick;
    pick = $urandom_range(0, 99);
    w.bus_address  = 16'($urandom);
    w.write_data   = 8'($urandom);
    w.rendering_on = ($urandom_range(0, 9) != 0);
    if (pick < 40) begin
      w.opcode = OP_WRITE;
      if ($urandom_range(0, 9) != 0) w.bus_address[15] = 1'b1;
      // keep the reload short so the counter expires often
      if ((w.bus_address & REG_MASK) == REG_IRQ_RELOAD && $urandom_range(0, 3) != 0)
        w.write_data = 8'($urandom_range(0, 6));
    end else if (pick < 70) begin
      w.opcode = OP_TICK;
    end else if (pick < 85) begin
      w.opcode = OP_PRG;
      if ($urandom_range(0, 4) != 0) w.bus_address[15] = 1'b1;
    end else begin
      w.opcode = OP_CHR;
      if ($urandom_range(0, 4) != 0) w.bus_address[15:13] = 3'b000;
    end
    return w;
  endfunction

  // present one word, with a random gap whenever a burst runs out
  task automatic offer(input in_word_t w);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 200)
                                               : $urandom_range(1, 30);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (results_due != 0) @(negedge clk);
  endtask

  task automatic set_config(input logic [7:0] top_bank, input logic four);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PRG_LAST;
    cfg_data  <= top_bank;
    @(negedge clk);
    cfg_index <= CFG_FOUR_SCREEN;
    cfg_data  <= {7'd0, four};
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    logic [7:0] last_plan [PHASES];
    logic       four_plan [PHASES];
    last_plan = '{8'd31, 8'd255, 8'd1, 8'd0, 8'd0};
    four_plan = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_PRG_LAST;
    cfg_data  = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES - 1)
        set_config(8'($urandom_range(2, 254)), 1'($urandom_range(0, 1)));
      else
        set_config(last_plan[ph], four_plan[ph]);

      if (ph == 0) begin
        offer(mk(OP_PRG, 16'h0000, 8'h00, 1'b0));   // below program space
        offer(mk(OP_CHR, 16'hFFFF, 8'hFF, 1'b1));   // above pattern space
        offer(mk(OP_WRITE, 16'h7FFF, 8'hFF, 1'b1)); // below register space
        offer(mk(OP_WRITE, REG_MODE, 8'h07, 1'b0));
        offer(mk(OP_WRITE, REG_BANK, 8'hFF, 1'b0));
        offer(mk(OP_PRG, 16'h8000, 8'h00, 1'b0));
        offer(mk(OP_PRG, 16'hBFFF, 8'h00, 1'b0));
        offer(mk(OP_PRG, 16'hDFFF, 8'h00, 1'b0));
        offer(mk(OP_PRG, 16'hFFFF, 8'h00, 1'b0));
        // swap program slots, invert pattern halves, select bank 0
        offer(mk(OP_WRITE, REG_MODE, 8'hC0, 1'b0));
        offer(mk(OP_WRITE, REG_BANK, 8'hFF, 1'b0));
        offer(mk(OP_PRG, 16'h9FFF, 8'h00, 1'b0));
        offer(mk(OP_PRG, 16'hC123, 8'h00, 1'b0));
        offer(mk(OP_CHR, 16'h0000, 8'h00, 1'b0));
        offer(mk(OP_CHR, 16'h1FFF, 8'h00, 1'b0));
        offer(mk(OP_CHR, 16'h17FF, 8'h00, 1'b0));
        offer(mk(OP_CHR, 16'h0C00, 8'h00, 1'b0));
        offer(mk(OP_WRITE, REG_MIRROR, 8'h00, 1'b0));
        offer(mk(OP_WRITE, REG_RAM_CTRL, 8'hC0, 1'b0));
        offer(mk(OP_WRITE, REG_IRQ_RELOAD, 8'h02, 1'b0));
        offer(mk(OP_WRITE, REG_IRQ_CLEAR, 8'h00, 1'b0));
        offer(mk(OP_WRITE, REG_IRQ_ON, 8'h00, 1'b0));
        offer(mk(OP_TICK, 16'h0000, 8'h00, 1'b0));  // rendering off: no count
        offer(mk(OP_TICK, 16'h0000, 8'h00, 1'b1));
        offer(mk(OP_TICK, 16'h0000, 8'h00, 1'b1));
        offer(mk(OP_TICK, 16'h0000, 8'h00, 1'b1));
        offer(mk(OP_WRITE, REG_IRQ_OFF, 8'h00, 1'b0));
      end

      repeat (RANDOM_WORDS / PHASES) offer(random_word());
      drain();
    end

    repeat (10) @(negedge clk);
    if (fail_count == 0 && results_due == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin : receiver
    rx_mode_t mode;
    int       mode_left;
    int       cycle_no;
    mode      = RX_FREE;
    mode_left = 0;
    cycle_no  = 0;
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      cycle_no++;
      // long hold-off: let the output back up into the input
      if (cycle_no == HOLD_AT) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (mode)
        RX_FREE:   out_ready <= 1'b1;
        RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
        default:   out_ready <= ((cycle_no % 5) < 3);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule

>>> filelist.f
hw/rtl/bsm_pkg.sv
hw/rtl/bsm_xlate.sv
hw/rtl/bank_switch_mapper_scanline_irq.sv
verif/mapper_checker.sv
verif/testbench.sv
